// ----- rtl/nsfc_pkg.sv -----
// Shared types, register codes and color helpers for the nearest scaler.
package nsfc_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W   = 12;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_H  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd4;

    localparam logic [1:0] FMT_BGRA   = 2'd0;
    localparam logic [1:0] FMT_RGBA   = 2'd1;
    localparam logic [1:0] FMT_RGBX   = 2'd2;
    localparam logic [1:0] FMT_RGB565 = 2'd3;

    localparam logic [CFG_W-1:0] SIZE_RESET = 13'd720;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic accept;
        logic mul;
        logic load;
        logic step;
        logic write;
    } ctrl_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic emit;
        logic wrap;
    } dp_status_t;

    // v * 255 / 31, truncated: exact reciprocal multiply over the 5-bit range.
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'd8625630;
        return p[27:20];
    endfunction

    // v * 255 / 63, truncated.
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [29:0] p;
        p = 30'(v) * 30'd8488695;
        return p[28:21];
    endfunction

endpackage

// ----- rtl/nearest_scaler_format_convert_top.sv -----
// Nearest-neighbor scaler with pixel format conversion to 8-bit RGB.
// A beat that produces no pixel, or that closes the source frame, leaves the sequencer idle.
// Any other beat that produces a pixel steps through the multiply, load, bit-serial divide
// and write states, which compute the next source pick position, before a new beat is taken.
// The result sits in an output register in the cycle after its input beat.
// Reset is synchronous: counters clear, sizes return to 720, format to BGRA.
module nearest_scaler_format_convert_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_word
    input  logic        s_tuser,   // first_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red, green, blue, dest_x, dest_y
    output logic        m_tlast,   // row_end
    output logic        m_tuser    // frame_end
);

    nsfc_pkg::ctrl_cmd_t  cmd;
    nsfc_pkg::dp_status_t status;

    nsfc_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nsfc_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ----- rtl/nsfc_ctrl.sv -----
// Sequencer: beat acceptance, output valid and the pick divider steps.
module nsfc_ctrl #(
    parameter int MAX_DIM = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  nsfc_pkg::dp_status_t status,
    output nsfc_pkg::ctrl_cmd_t  cmd
);

    localparam int SZ_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(SZ_W);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic m_valid_reg, m_valid_next;
    logic accept;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = accept;
                if (accept && status.emit) begin
                    m_valid_next = 1'b1;
                    // the frame wrap clears the picks, so skip the divide
                    if (!status.wrap) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SZ_W - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/nsfc_dp.sv -----
// Datapath: config registers, position counters, pick divider, color convert.
module nsfc_dp #(
    parameter int MAX_DIM = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [nsfc_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [nsfc_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic [31:0]                       s_tdata,
    input  logic                              s_tuser,
    output logic [47:0]                       m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser,
    input  nsfc_pkg::ctrl_cmd_t               cmd,
    output nsfc_pkg::dp_status_t              status
);

    localparam int SZ_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (SZ_W > nsfc_pkg::CFG_W) ? SZ_W : nsfc_pkg::CFG_W;
    localparam int EXT_W = (SZ_W > nsfc_pkg::COORD_W) ? SZ_W : nsfc_pkg::COORD_W;

    logic [nsfc_pkg::CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [1:0]                 fmt_reg;

    logic [SZ_W-1:0] src_col_reg, src_row_reg, dst_col_reg, dst_row_reg;
    logic [SZ_W-1:0] pick_col_reg, pick_row_reg;
    logic [SZ_W-1:0] src_col_next, src_row_next, dst_col_next, dst_row_next;
    logic [SZ_W-1:0] pick_col_next, pick_row_next;

    logic [SZ_W-1:0]   mul_a_reg, mul_b_reg, dvs_reg;
    logic              tgt_row_reg;
    logic [SZ_W-1:0]   mul_a_next, mul_b_next, dvs_next;
    logic              tgt_row_next;
    logic [2*SZ_W-1:0] prod_reg;
    logic [SZ_W-1:0]   rem_reg, quo_reg;
    logic [SZ_W:0]     rem_sh;
    logic              q_bit;

    logic [SZ_W-1:0] sw, sh, dw, dh;
    logic [CMP_W-1:0] sw_ext, sh_ext, dw_ext, dh_ext;
    logic [SZ_W-1:0] c_src_col, c_src_row, c_dst_col, c_dst_row, c_pick_col, c_pick_row;
    logic emit, rend, fend, col_end, wrap;

    logic [7:0] red, green, blue;
    logic [EXT_W-1:0] dx_ext, dy_ext;
    logic [47:0] out_data_reg;
    logic out_last_reg, out_user_reg;

    // Effective sizes: zero counts as one, sources cap at MAX_DIM, dest caps at source.
    always_comb begin
        sw_ext = CMP_W'(src_w_reg);
        sh_ext = CMP_W'(src_h_reg);
        if (sw_ext == '0) begin
            sw = SZ_W'(1);
        end else if (sw_ext > CMP_W'(MAX_DIM)) begin
            sw = SZ_W'(MAX_DIM);
        end else begin
            sw = SZ_W'(sw_ext);
        end
        if (sh_ext == '0) begin
            sh = SZ_W'(1);
        end else if (sh_ext > CMP_W'(MAX_DIM)) begin
            sh = SZ_W'(MAX_DIM);
        end else begin
            sh = SZ_W'(sh_ext);
        end
        dw_ext = CMP_W'(dst_w_reg);
        dh_ext = CMP_W'(dst_h_reg);
        if (dw_ext == '0) begin
            dw = SZ_W'(1);
        end else if (dw_ext > CMP_W'(sw)) begin
            dw = sw;
        end else begin
            dw = SZ_W'(dw_ext);
        end
        if (dh_ext == '0) begin
            dh = SZ_W'(1);
        end else if (dh_ext > CMP_W'(sh)) begin
            dh = sh;
        end else begin
            dh = SZ_W'(dh_ext);
        end
    end

    // Start of frame drops all counters before the beat is used.
    assign c_src_col  = s_tuser ? '0 : src_col_reg;
    assign c_src_row  = s_tuser ? '0 : src_row_reg;
    assign c_dst_col  = s_tuser ? '0 : dst_col_reg;
    assign c_dst_row  = s_tuser ? '0 : dst_row_reg;
    assign c_pick_col = s_tuser ? '0 : pick_col_reg;
    assign c_pick_row = s_tuser ? '0 : pick_row_reg;

    assign emit    = (c_src_row == c_pick_row) && (c_src_col == c_pick_col)
                     && (c_dst_row < dh) && (c_dst_col < dw);
    assign rend    = (c_dst_col == dw - 1'b1);
    assign fend    = rend && (c_dst_row == dh - 1'b1);
    assign col_end = (c_src_col >= sw - 1'b1);
    assign wrap    = col_end && (c_src_row >= sh - 1'b1);

    assign status.emit = emit;
    assign status.wrap = wrap;

    always_comb begin
        src_col_next  = c_src_col;
        src_row_next  = c_src_row;
        dst_col_next  = c_dst_col;
        dst_row_next  = c_dst_row;
        pick_col_next = c_pick_col;
        pick_row_next = c_pick_row;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        dvs_next      = dvs_reg;
        tgt_row_next  = tgt_row_reg;
        if (emit) begin
            if (rend) begin
                dst_col_next  = '0;
                dst_row_next  = c_dst_row + 1'b1;
                pick_col_next = '0;
                mul_a_next    = c_dst_row + 1'b1;
                mul_b_next    = sh;
                dvs_next      = dh;
                tgt_row_next  = 1'b1;
            end else begin
                dst_col_next = c_dst_col + 1'b1;
                mul_a_next   = c_dst_col + 1'b1;
                mul_b_next   = sw;
                dvs_next     = dw;
                tgt_row_next = 1'b0;
            end
        end
        if (col_end) begin
            src_col_next = '0;
            if (wrap) begin
                src_row_next  = '0;
                dst_col_next  = '0;
                dst_row_next  = '0;
                pick_col_next = '0;
                pick_row_next = '0;
            end else begin
                src_row_next = c_src_row + 1'b1;
            end
        end else begin
            src_col_next = c_src_col + 1'b1;
        end
    end

    // Restoring divide step: one quotient bit per cycle.
    assign rem_sh = {rem_reg, quo_reg[SZ_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvs_reg});

    always_comb begin
        red   = s_tdata[7:0];
        green = s_tdata[15:8];
        blue  = s_tdata[23:16];
        unique case (fmt_reg) inside
            nsfc_pkg::FMT_BGRA: begin
                red  = s_tdata[23:16];
                blue = s_tdata[7:0];
            end
            nsfc_pkg::FMT_RGBA, nsfc_pkg::FMT_RGBX: begin
                red  = s_tdata[7:0];
                blue = s_tdata[23:16];
            end
            nsfc_pkg::FMT_RGB565: begin
                red   = nsfc_pkg::expand5(s_tdata[15:11]);
                green = nsfc_pkg::expand6(s_tdata[10:5]);
                blue  = nsfc_pkg::expand5(s_tdata[4:0]);
            end
            default: begin
                red = s_tdata[7:0];
            end
        endcase
    end

    assign dx_ext = EXT_W'(c_dst_col);
    assign dy_ext = EXT_W'(c_dst_row);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg    <= nsfc_pkg::SIZE_RESET;
            src_h_reg    <= nsfc_pkg::SIZE_RESET;
            dst_w_reg    <= nsfc_pkg::SIZE_RESET;
            dst_h_reg    <= nsfc_pkg::SIZE_RESET;
            fmt_reg      <= nsfc_pkg::FMT_BGRA;
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            dst_col_reg  <= '0;
            dst_row_reg  <= '0;
            pick_col_reg <= '0;
            pick_row_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    nsfc_pkg::REG_SRC_W:  src_w_reg <= cfg_wr_data;
                    nsfc_pkg::REG_SRC_H:  src_h_reg <= cfg_wr_data;
                    nsfc_pkg::REG_DST_W:  dst_w_reg <= cfg_wr_data;
                    nsfc_pkg::REG_DST_H:  dst_h_reg <= cfg_wr_data;
                    nsfc_pkg::REG_FORMAT: fmt_reg   <= cfg_wr_data[1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.accept) begin
                src_col_reg  <= src_col_next;
                src_row_reg  <= src_row_next;
                dst_col_reg  <= dst_col_next;
                dst_row_reg  <= dst_row_next;
                pick_col_reg <= pick_col_next;
                pick_row_reg <= pick_row_next;
            end else if (cmd.write) begin
                if (tgt_row_reg) begin
                    pick_row_reg <= quo_reg;
                end else begin
                    pick_col_reg <= quo_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mul_a_reg   <= mul_a_next;
            mul_b_reg   <= mul_b_next;
            dvs_reg     <= dvs_next;
            tgt_row_reg <= tgt_row_next;
        end
        if (cmd.accept && emit) begin
            out_data_reg <= {dy_ext[nsfc_pkg::COORD_W-1:0], dx_ext[nsfc_pkg::COORD_W-1:0],
                             blue, green, red};
            out_last_reg <= rend;
            out_user_reg <= fend;
        end
        if (cmd.mul) begin
            prod_reg <= mul_a_reg * mul_b_reg;
        end
        if (cmd.load) begin
            rem_reg <= prod_reg[2*SZ_W-1:SZ_W];
            quo_reg <= prod_reg[SZ_W-1:0];
        end else if (cmd.step) begin
            rem_reg <= q_bit ? SZ_W'(rem_sh - {1'b0, dvs_reg}) : SZ_W'(rem_sh);
            quo_reg <= {quo_reg[SZ_W-2:0], q_bit};
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;
    assign m_tuser = out_user_reg;

endmodule

// ----- verif/tb_nearest_scaler_format_convert_top.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the nearest-neighbor scaler with format conversion.
module tb_nearest_scaler_format_convert_top;

    localparam int MAX_DIM      = 4096;
    localparam int DRAIN_CYCLES = 40;    // well past the pick divider
    localparam int STALL_LIMIT  = 5000;
    localparam int TARGET_ITEMS = 1750;
    localparam int CFG_W        = nsfc_pkg::CFG_W;
    localparam int CFG_IDX_W    = nsfc_pkg::CFG_IDX_W;

    typedef struct packed {
        logic [31:0] word;
        logic        sof;
    } src_pixel_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic        row_end;
        logic        frame_end;
    } scaled_pixel_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data  = '0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata      = '0;
    logic                 s_tuser      = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    nearest_scaler_format_convert_top #(.MAX_DIM(MAX_DIM)) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    src_pixel_t    pending_pixels[$];
    scaled_pixel_t expected_pixels[$];

    int mismatches     = 0;
    int items_queued   = 0;
    int items_accepted = 0;
    int pixels_checked = 0;
    int frames_seen    = 0;
    int phase_count    = 0;
    bit source_bursty  = 1'b0;
    bit sink_bursty    = 1'b0;

    // Shadow registers and scan position of the scaler
    logic [CFG_W-1:0] cfg_src_w, cfg_src_h, cfg_dst_w, cfg_dst_h;
    logic [1:0]       cfg_format;
    int unsigned      scan_col, scan_row, out_col, out_row, want_col, want_row;

    function automatic int idle_gap(input bit bursty);
        int r;
        if (bursty) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int unsigned fit_size(input int unsigned v, input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int unsigned pick_index(input int unsigned d, input int unsigned s,
                                               input int unsigned dsz);
        return int'((longint'(d) * longint'(s)) / longint'(dsz));
    endfunction

    function automatic void clear_scan();
        scan_col = 0;
        scan_row = 0;
        out_col  = 0;
        out_row  = 0;
        want_col = 0;
        want_row = 0;
    endfunction

    // Advance the scan by one source pixel; return 1 when it is picked for output.
    function automatic bit scale_step(input logic [31:0] word, input logic sof,
                                      output scaled_pixel_t px);
        int unsigned sw, sh, dw, dh;
        bit hit;
        sw  = fit_size(cfg_src_w, MAX_DIM);
        sh  = fit_size(cfg_src_h, MAX_DIM);
        dw  = fit_size(cfg_dst_w, sw);
        dh  = fit_size(cfg_dst_h, sh);
        hit = 1'b0;
        px  = '0;
        if (sof) clear_scan();
        if (scan_row == want_row && scan_col == want_col && out_row < dh && out_col < dw) begin
            hit = 1'b1;
            case (cfg_format)
                nsfc_pkg::FMT_BGRA: begin
                    px.red   = word[23:16];
                    px.green = word[15:8];
                    px.blue  = word[7:0];
                end
                nsfc_pkg::FMT_RGB565: begin
                    px.red   = 8'(int'(word[15:11]) * 255 / 31);
                    px.green = 8'(int'(word[10:5]) * 255 / 63);
                    px.blue  = 8'(int'(word[4:0]) * 255 / 31);
                end
                default: begin
                    px.red   = word[7:0];
                    px.green = word[15:8];
                    px.blue  = word[23:16];
                end
            endcase
            px.dest_x    = out_col[11:0];
            px.dest_y    = out_row[11:0];
            px.row_end   = (out_col == dw - 1);
            px.frame_end = px.row_end && (out_row == dh - 1);
            if (px.row_end) begin
                out_col  = 0;
                out_row++;
                want_col = 0;
                want_row = pick_index(out_row, sh, dh);
            end else begin
                out_col++;
                want_col = pick_index(out_col, sw, dw);
            end
        end
        if (scan_col >= sw - 1) begin
            scan_col = 0;
            if (scan_row >= sh - 1) clear_scan();
            else scan_row++;
        end else begin
            scan_col++;
        end
        return hit;
    endfunction

    // Track register writes and accepted source beats
    always @(posedge aclk) begin
        scaled_pixel_t px;
        if (!aresetn) begin
            cfg_src_w  = nsfc_pkg::SIZE_RESET;
            cfg_src_h  = nsfc_pkg::SIZE_RESET;
            cfg_dst_w  = nsfc_pkg::SIZE_RESET;
            cfg_dst_h  = nsfc_pkg::SIZE_RESET;
            cfg_format = nsfc_pkg::FMT_BGRA;
            clear_scan();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    nsfc_pkg::REG_SRC_W:  cfg_src_w  = cfg_wr_data;
                    nsfc_pkg::REG_SRC_H:  cfg_src_h  = cfg_wr_data;
                    nsfc_pkg::REG_DST_W:  cfg_dst_w  = cfg_wr_data;
                    nsfc_pkg::REG_DST_H:  cfg_dst_h  = cfg_wr_data;
                    nsfc_pkg::REG_FORMAT: cfg_format = cfg_wr_data[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                items_accepted++;
                if (scale_step(s_tdata, s_tuser, px)) expected_pixels.push_back(px);
            end
        end
    end

    // Source driver
    int src_gap = 0;
    always @(posedge aclk) begin
        src_pixel_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                beat = pending_pixels.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= beat.word;
                s_tuser  <= beat.sof;
                src_gap = idle_gap(source_bursty);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(input string what, input scaled_pixel_t want,
                                 input scaled_pixel_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected r=%02h g=%02h b=%02h x=%0d y=%0d row_end=%0b frame_end=%0b",
                     want.red, want.green, want.blue, want.dest_x, want.dest_y,
                     want.row_end, want.frame_end);
            $display("  actual   r=%02h g=%02h b=%02h x=%0d y=%0d row_end=%0b frame_end=%0b",
                     got.red, got.green, got.blue, got.dest_x, got.dest_y,
                     got.row_end, got.frame_end);
        end
    endtask

    // Result monitor with random backpressure
    int sink_gap = 0;
    always @(posedge aclk) begin
        scaled_pixel_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.red       = m_tdata[7:0];
                got.green     = m_tdata[15:8];
                got.blue      = m_tdata[23:16];
                got.dest_x    = m_tdata[35:24];
                got.dest_y    = m_tdata[47:36];
                got.row_end   = m_tlast;
                got.frame_end = m_tuser;
                if (expected_pixels.size() == 0) begin
                    note_mismatch("output beat with no pixel expected", '0, got);
                end else begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (got !== want) note_mismatch("scaled pixel mismatch", want, got);
                    else if (got.frame_end) frames_seen++;
                end
            end
            if ($urandom_range(0, 255) == 0) sink_bursty = ~sink_bursty;
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap = idle_gap(sink_bursty);
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog: no handshake for %0d cycles, %0d pixels outstanding",
                     $realtime, STALL_LIMIT, expected_pixels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
    endtask

    task automatic finish_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic program_sizes(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                                 input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dh,
                                 input logic [1:0] fmt);
        set_reg(nsfc_pkg::REG_SRC_W, sw);
        set_reg(nsfc_pkg::REG_SRC_H, sh);
        set_reg(nsfc_pkg::REG_DST_W, dw);
        set_reg(nsfc_pkg::REG_DST_H, dh);
        set_reg(nsfc_pkg::REG_FORMAT, CFG_W'(fmt));
        finish_writes();
    endtask

    task automatic send_pixel(input logic [31:0] word, input logic sof);
        src_pixel_t p;
        p.word = word;
        p.sof  = sof;
        pending_pixels.push_back(p);
        items_queued++;
    endtask

    task automatic queue_pixels(input int count, input bit mark_first, input bit noisy);
        logic [31:0] word;
        logic        sof;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 15))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            sof = (i == 0) ? mark_first : 1'b0;
            if (noisy && $urandom_range(0, 15) == 0) sof = 1'b1;
            send_pixel(word, sof);
        end
    endtask

    // Hold until the source is drained and every expected pixel has come out
    task automatic drain();
        do @(negedge aclk);
        while (pending_pixels.size() != 0 || s_tvalid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int  r, count, frames, cur_sw, cur_sh, eff_w, eff_h;
        bit  mark, noisy;
        cur_sw = 720;
        cur_sh = 720;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset sizes and format: every pixel of a 720x720 frame is kept
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0012_3456, 1'b0);
        send_pixel(32'hA5C3_0F81, 1'b0);
        drain();

        // One-to-one frame, ends with a frame end
        program_sizes(13'd3, 13'd2, 13'd3, 13'd2, nsfc_pkg::FMT_RGBA);
        send_pixel(32'h1122_3344, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h8040_2010, 1'b0);
        send_pixel(32'h0102_0304, 1'b0);
        send_pixel(32'hDEAD_BEEF, 1'b0);
        drain();

        // 565 expansion at channel extremes, 2:1 in columns
        program_sizes(13'd4, 13'd2, 13'd2, 13'd2, nsfc_pkg::FMT_RGB565);
        send_pixel(32'h0000_FFFF, 1'b1);
        send_pixel(32'h0000_1234, 1'b0);
        send_pixel(32'hFFFF_07E0, 1'b0);
        send_pixel(32'h0000_5678, 1'b0);
        send_pixel(32'hABCD_F800, 1'b0);
        send_pixel(32'h0000_AAAA, 1'b0);
        send_pixel(32'h0000_001F, 1'b0);
        send_pixel(32'h0000_BBBB, 1'b0);
        drain();

        // Zero and oversized sizes clamp: one-pixel rows, 4096 rows
        program_sizes(13'd0, 13'd8191, 13'd0, 13'd8191, nsfc_pkg::FMT_RGBX);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h8040_2010, 1'b0);
        send_pixel(32'h0102_0304, 1'b0);
        drain();

        // Widest row, destination clamped to the source
        program_sizes(13'd4096, 13'd1, 13'd8191, 13'd2, nsfc_pkg::FMT_BGRA);
        send_pixel(32'h00FF_00FF, 1'b1);
        send_pixel(32'hFF00_FF00, 1'b0);
        send_pixel(32'h7F80_017E, 1'b0);
        drain();

        while (items_queued < TARGET_ITEMS) begin
            r = $urandom_range(0, 19);
            source_bursty = ($urandom_range(0, 3) == 0);
            if (r == 0) begin
                // wide partial row
                cur_sw = $urandom_range(1000, 8191);
                cur_sh = $urandom_range(0, 3);
                program_sizes(CFG_W'(cur_sw), CFG_W'(cur_sh), CFG_W'($urandom_range(0, 8191)),
                              CFG_W'($urandom_range(0, 4)), 2'($urandom_range(0, 3)));
                count = $urandom_range(20, 40);
                mark  = 1'b1;
                noisy = 1'b0;
            end else if (r == 1) begin
                // tall frame with one- or two-pixel rows
                cur_sw = $urandom_range(0, 2);
                cur_sh = $urandom_range(1000, 8191);
                program_sizes(CFG_W'(cur_sw), CFG_W'(cur_sh), CFG_W'($urandom_range(0, 3)),
                              CFG_W'($urandom_range(0, 8191)), 2'($urandom_range(0, 3)));
                count = $urandom_range(20, 40);
                mark  = 1'b1;
                noisy = 1'b0;
            end else if (r < 5) begin
                // resize and reformat in the middle of a frame
                set_reg(nsfc_pkg::REG_DST_W, CFG_W'($urandom_range(0, cur_sw + 2)));
                set_reg(nsfc_pkg::REG_DST_H, CFG_W'($urandom_range(0, cur_sh + 2)));
                if ($urandom_range(0, 1) == 1) begin
                    set_reg(nsfc_pkg::REG_SRC_W, CFG_W'($urandom_range(0, 12)));
                end
                set_reg(nsfc_pkg::REG_FORMAT, CFG_W'($urandom_range(0, 3)));
                finish_writes();
                count = $urandom_range(5, 30);
                mark  = 1'b0;
                noisy = 1'b0;
            end else begin
                cur_sw = $urandom_range(0, 12);
                cur_sh = $urandom_range(0, 8);
                program_sizes(CFG_W'(cur_sw), CFG_W'(cur_sh),
                              CFG_W'($urandom_range(0, cur_sw + 2)),
                              CFG_W'($urandom_range(0, cur_sh + 2)), 2'($urandom_range(0, 3)));
                eff_w  = (cur_sw == 0) ? 1 : cur_sw;
                eff_h  = (cur_sh == 0) ? 1 : cur_sh;
                frames = $urandom_range(1, 3);
                count  = frames * eff_w * eff_h;
                noisy  = ($urandom_range(0, 4) == 0);
                if (noisy) count = $urandom_range(1, count);
                mark   = ($urandom_range(0, 7) != 0);
            end
            queue_pixels(count, mark, noisy);
            drain();
            phase_count++;
        end

        $display("Covered %0d source beats over %0d random settings plus directed cases;",
                 items_accepted, phase_count);
        $display("checked %0d scaled pixels, %0d complete destination frames, 4 formats.",
                 pixels_checked, frames_seen);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
